// ===== rtl/tps_pkg.sv =====
`timescale 1ns / 1ps
package tps_pkg;

  // action codes of an input beat
  typedef enum logic [3:0] {
    ACT_ADD       = 4'd0,
    ACT_CANCEL    = 4'd1,
    ACT_SET_IVAL  = 4'd2,
    ACT_SET_REPS  = 4'd3,
    ACT_QUERY     = 4'd4,
    ACT_SCAN      = 4'd5,
    ACT_DISPATCH  = 4'd6,
    ACT_BUDGET    = 4'd7,
    ACT_TASK_DONE = 4'd8
  } action_t;

  // result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_NOT_DUE   = 2'd3;

  // table select and flag bits
  localparam logic LIST_HI = 1'b0;
  localparam logic LIST_LO = 1'b1;
  localparam int FLAG_CANCEL = 0;
  localparam int FLAG_DUE    = 1;

  localparam logic [7:0] STARVE_RESET = 8'd5;

  typedef struct packed {
    logic [3:0]  action;
    logic [31:0] now_ms;
    logic [15:0] task_id;
    logic        high_priority;
    logic [31:0] period_ms;
    logic [15:0] repetitions;
    logic        start_now;
    logic        keep_going;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] result_id;
    logic        result_high;
    logic        completed;
  } out_beat_t;

  // commands from controller to datapath
  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_ADD,
    CMD_FIND_INIT,
    CMD_NEXT_LIST,
    CMD_PTR_INC,
    CMD_LATCH,
    CMD_DIFF,
    CMD_APPLY,
    CMD_NOT_FOUND,
    CMD_SCAN_INIT,
    CMD_SCAN_STEP,
    CMD_SCAN_END,
    CMD_WALK_HI,
    CMD_WALK_LO,
    CMD_WALK_STEP,
    CMD_WALK_END,
    CMD_WALK_HIT,
    CMD_NOT_DUE,
    CMD_AGE_INIT,
    CMD_AGE_INC,
    CMD_OUT
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic [3:0] action;
    logic       ptr_end;
    logic       walk_end;
    logic       id_match;
    logic       runnable;
    logic       list_lo;
    logic       age_ge;
    logic       out_busy;
  } dp_status_t;

endpackage

// ===== rtl/tps_ram.sv =====
`timescale 1ns / 1ps
module tps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/tps_datapath.sv =====
`timescale 1ns / 1ps
module tps_datapath #(
  parameter int TASKS_PER_LIST = 16,
  parameter int ID_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  tps_pkg::cmd_t       cmd,
  output tps_pkg::dp_status_t st,
  input  tps_pkg::in_beat_t   in_data,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_wdata,
  output logic                out_valid,
  input  logic                out_ready,
  output tps_pkg::out_beat_t  out_data
);

  localparam int IW = (TASKS_PER_LIST > 1) ? $clog2(TASKS_PER_LIST) : 1;
  localparam int CW = $clog2(TASKS_PER_LIST + 1);
  localparam int AW = IW + 1;
  localparam logic [CW-1:0] TMAX = CW'(TASKS_PER_LIST);

  typedef struct packed {
    logic [ID_BITS-1:0] id;
    logic [31:0]        ival;
    logic [31:0]        deadline;
    logic [15:0]        reps;
    logic [15:0]        runs;
    logic [1:0]         flags;
  } entry_t;

  localparam int EW = $bits(entry_t);

  tps_pkg::in_beat_t ib;
  logic [CW-1:0] cnt [2];
  logic [CW-1:0] cur [2];
  logic [ID_BITS-1:0] next_id;
  logic [7:0] age;
  logic [7:0] limit;
  logic list;
  logic [CW-1:0] ptr;
  logic [CW-1:0] k;
  logic [CW-1:0] outc;
  logic [CW-1:0] newcur;
  entry_t ent;
  logic [31:0] d_up;
  logic [31:0] d_dn;
  logic ival_gt;
  logic ival_lt;
  tps_pkg::out_beat_t res;

  entry_t rd_e;
  logic [EW-1:0] rd_raw;
  logic we;
  logic [AW-1:0] waddr;
  entry_t wdata;
  logic [AW-1:0] raddr;

  logic add_l;
  logic [ID_BITS-1:0] nid_inc;
  logic [ID_BITS-1:0] nid;
  logic e_done;
  entry_t marked;
  logic [32:0] mark_sum;
  entry_t applied;
  logic [32:0] up_sum;
  logic [15:0] runs_inc;

  function automatic logic [CW-1:0] step_back(input logic [CW-1:0] c, input logic [CW-1:0] n);
    step_back = (c == '0 || c >= n) ? n - CW'(1) : c - CW'(1);
  endfunction

  assign raddr = {list, ptr[IW-1:0]};
  assign rd_e  = entry_t'(rd_raw);

  tps_ram #(.WIDTH(EW), .DEPTH(2 ** AW)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rd_raw)
  );

  // add helpers
  assign add_l   = ib.high_priority ? tps_pkg::LIST_HI : tps_pkg::LIST_LO;
  assign nid_inc = next_id + ID_BITS'(1);
  assign nid     = (nid_inc == '0) ? ID_BITS'(1) : nid_inc;

  // scan: finished check and due marking of the entry just read
  assign e_done   = (rd_e.reps != '0 && rd_e.runs == rd_e.reps) ||
                    rd_e.flags[tps_pkg::FLAG_CANCEL];
  assign mark_sum = {1'b0, ib.now_ms} + {1'b0, rd_e.ival};
  always_comb begin
    marked = rd_e;
    if (ib.now_ms > rd_e.deadline) begin
      marked.flags[tps_pkg::FLAG_DUE] = (rd_e.deadline != '0);
      marked.deadline = mark_sum[32] ? '1 : mark_sum[31:0];
    end
  end

  // update of a found entry
  assign up_sum   = {1'b0, ent.deadline} + {1'b0, d_up};
  assign runs_inc = (ent.runs != 16'hffff) ? ent.runs + 16'd1 : ent.runs;
  always_comb begin
    applied = ent;
    case (ib.action)
      tps_pkg::ACT_CANCEL: begin
        applied.flags[tps_pkg::FLAG_CANCEL] = 1'b1;
      end
      tps_pkg::ACT_SET_IVAL: begin
        applied.ival = ib.period_ms;
        if (ent.deadline != '0) begin
          if (ival_gt) begin
            applied.deadline = up_sum[32] ? '1 : up_sum[31:0];
          end else if (ival_lt) begin
            applied.deadline = (ent.deadline > d_dn) ? ent.deadline - d_dn : 32'd1;
          end
        end
      end
      tps_pkg::ACT_SET_REPS: begin
        applied.reps = ib.repetitions;
      end
      tps_pkg::ACT_TASK_DONE: begin
        if (!ib.keep_going) begin
          applied.flags[tps_pkg::FLAG_DUE] = 1'b0;
          applied.runs = runs_inc;
        end
      end
      default: begin
      end
    endcase
  end

  // memory write port
  always_comb begin
    we    = 1'b0;
    waddr = {list, ptr[IW-1:0]};
    wdata = applied;
    case (cmd)
      tps_pkg::CMD_ADD: begin
        we    = (cnt[add_l] < TMAX);
        waddr = {add_l, cnt[add_l][IW-1:0]};
        wdata.id       = nid;
        wdata.ival     = ib.period_ms;
        wdata.deadline = ib.start_now ? ib.now_ms : 32'd0;
        wdata.reps     = ib.repetitions;
        wdata.runs     = '0;
        wdata.flags    = '0;
      end
      tps_pkg::CMD_SCAN_STEP: begin
        we    = !e_done;
        waddr = {list, outc[IW-1:0]};
        wdata = marked;
      end
      tps_pkg::CMD_APPLY: begin
        we = (ib.action != tps_pkg::ACT_QUERY);
      end
      default: begin
      end
    endcase
  end

  // status to controller
  always_comb begin
    st.action   = ib.action;
    st.ptr_end  = (ptr >= cnt[list]);
    st.walk_end = (k >= cnt[list]);
    st.id_match = (32'(rd_e.id) == 32'(ib.task_id));
    st.runnable = rd_e.flags[tps_pkg::FLAG_DUE] && !rd_e.flags[tps_pkg::FLAG_CANCEL];
    st.list_lo  = (list == tps_pkg::LIST_LO);
    st.age_ge   = (age >= limit);
    st.out_busy = out_valid && !out_ready;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt[0] <= '0;
      cnt[1] <= '0;
      cur[0] <= '0;
      cur[1] <= '0;
      next_id <= '0;
      age <= '0;
      limit <= tps_pkg::STARVE_RESET;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        limit <= cfg_wdata;
      end
      if (cmd == tps_pkg::CMD_OUT) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (cmd)
        tps_pkg::CMD_ADD: begin
          if (cnt[add_l] < TMAX) begin
            next_id <= nid;
            cnt[add_l] <= cnt[add_l] + CW'(1);
            cur[add_l] <= (cur[add_l] + CW'(1) >= cnt[add_l] + CW'(1)) ?
                          cnt[add_l] : cur[add_l] + CW'(1);
          end
        end
        tps_pkg::CMD_APPLY: begin
          if (ib.action == tps_pkg::ACT_TASK_DONE && ptr == cur[list] &&
              (!applied.flags[tps_pkg::FLAG_DUE] || applied.flags[tps_pkg::FLAG_CANCEL])) begin
            cur[list] <= step_back(cur[list], cnt[list]);
          end
        end
        tps_pkg::CMD_SCAN_END: begin
          cnt[list] <= outc;
          if (outc == '0) begin
            cur[list] <= '0;
          end else if (newcur >= outc) begin
            cur[list] <= outc - CW'(1);
          end else begin
            cur[list] <= newcur;
          end
        end
        tps_pkg::CMD_WALK_END: begin
          if (cnt[list] != '0) begin
            cur[list] <= ptr;
          end
        end
        tps_pkg::CMD_WALK_HIT: begin
          cur[list] <= ptr;
          if (list == tps_pkg::LIST_LO) begin
            age <= '0;
          end
        end
        tps_pkg::CMD_AGE_INC: begin
          if (age != 8'hff) begin
            age <= age + 8'd1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // working registers and result
  always_ff @(posedge clk) begin
    case (cmd)
      tps_pkg::CMD_LOAD: begin
        ib  <= in_data;
        res <= '0;
      end
      tps_pkg::CMD_ADD: begin
        if (cnt[add_l] < TMAX) begin
          res.result_id <= 16'(nid);
        end else begin
          res.status <= tps_pkg::ST_FULL;
        end
      end
      tps_pkg::CMD_FIND_INIT: begin
        list <= tps_pkg::LIST_HI;
        ptr  <= '0;
      end
      tps_pkg::CMD_NEXT_LIST: begin
        list <= tps_pkg::LIST_LO;
        ptr  <= '0;
      end
      tps_pkg::CMD_AGE_INIT: begin
        list <= tps_pkg::LIST_LO;
        ptr  <= '0;
      end
      tps_pkg::CMD_PTR_INC: begin
        ptr <= ptr + CW'(1);
      end
      tps_pkg::CMD_LATCH: begin
        ent <= rd_e;
      end
      tps_pkg::CMD_DIFF: begin
        d_up    <= ib.period_ms - ent.ival;
        d_dn    <= ent.ival - ib.period_ms;
        ival_gt <= ib.period_ms > ent.ival;
        ival_lt <= ib.period_ms < ent.ival;
      end
      tps_pkg::CMD_NOT_FOUND: begin
        if (ib.action == tps_pkg::ACT_QUERY) begin
          res.completed <= 1'b1;
        end else begin
          res.status <= tps_pkg::ST_NOT_FOUND;
        end
      end
      tps_pkg::CMD_SCAN_INIT: begin
        list   <= tps_pkg::LIST_HI;
        ptr    <= '0;
        outc   <= '0;
        newcur <= cur[0];
      end
      tps_pkg::CMD_SCAN_STEP: begin
        ptr <= ptr + CW'(1);
        if (e_done) begin
          if (ptr == cur[list]) begin
            newcur <= outc - CW'(1);
          end
        end else begin
          if (ptr == cur[list]) begin
            newcur <= outc;
          end
          outc <= outc + CW'(1);
        end
      end
      tps_pkg::CMD_SCAN_END: begin
        list   <= tps_pkg::LIST_LO;
        ptr    <= '0;
        outc   <= '0;
        newcur <= cur[1];
      end
      tps_pkg::CMD_WALK_HI, tps_pkg::CMD_WALK_LO: begin
        list <= (cmd == tps_pkg::CMD_WALK_LO);
        k    <= '0;
        if (cmd == tps_pkg::CMD_WALK_LO) begin
          ptr <= (cur[1] >= cnt[1]) ? cnt[1] - CW'(1) : cur[1];
        end else begin
          ptr <= (cur[0] >= cnt[0]) ? cnt[0] - CW'(1) : cur[0];
        end
      end
      tps_pkg::CMD_WALK_STEP: begin
        ptr <= step_back(ptr, cnt[list]);
        k   <= k + CW'(1);
      end
      tps_pkg::CMD_WALK_HIT: begin
        res.result_id   <= 16'(rd_e.id);
        res.result_high <= (list == tps_pkg::LIST_HI);
      end
      tps_pkg::CMD_NOT_DUE: begin
        res.status <= tps_pkg::ST_NOT_DUE;
      end
      tps_pkg::CMD_OUT: begin
        out_data <= res;
      end
      default: begin
      end
    endcase
  end

  // table invariants and the result load check
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt[0] <= TMAX && cnt[1] <= TMAX)
    else $error("task count beyond table size");
  a_cur_bound: assert property (@(posedge clk) disable iff (rst)
    (cur[0] < cnt[0] || cur[0] == '0) && (cur[1] < cnt[1] || cur[1] == '0))
    else $error("cursor outside its table");
  a_out_load: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd == tps_pkg::CMD_OUT))
    else $error("result beat raised without a load");

endmodule

// ===== rtl/tps_ctrl.sv =====
`timescale 1ns / 1ps
module tps_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  tps_pkg::dp_status_t st,
  output tps_pkg::cmd_t       cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_FIND_RD, S_FIND_EX, S_DIFF, S_APPLY, S_SCAN_RD, S_SCAN_EX,
    S_WALK_RD, S_WALK_EX, S_WALK_NEXT, S_AGE_RD, S_AGE_EX, S_FIN
  } state_t;

  typedef enum logic [1:0] {
    PH_HI_FIRST, PH_LO, PH_HI_LAST
  } phase_t;

  state_t state, state_next;
  phase_t phase, phase_next;

  assign in_ready = (state == S_IDLE);

  // next state and command
  always_comb begin
    state_next = state;
    phase_next = phase;
    cmd = tps_pkg::CMD_NONE;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd = tps_pkg::CMD_LOAD;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        case (st.action)
          tps_pkg::ACT_ADD: begin
            cmd = tps_pkg::CMD_ADD;
            state_next = S_FIN;
          end
          tps_pkg::ACT_CANCEL, tps_pkg::ACT_SET_IVAL, tps_pkg::ACT_SET_REPS,
          tps_pkg::ACT_QUERY, tps_pkg::ACT_TASK_DONE: begin
            cmd = tps_pkg::CMD_FIND_INIT;
            state_next = S_FIND_RD;
          end
          tps_pkg::ACT_SCAN: begin
            cmd = tps_pkg::CMD_SCAN_INIT;
            state_next = S_SCAN_RD;
          end
          tps_pkg::ACT_DISPATCH: begin
            if (st.age_ge) begin
              cmd = tps_pkg::CMD_WALK_LO;
              phase_next = PH_LO;
            end else begin
              cmd = tps_pkg::CMD_WALK_HI;
              phase_next = PH_HI_FIRST;
            end
            state_next = S_WALK_RD;
          end
          tps_pkg::ACT_BUDGET: begin
            cmd = tps_pkg::CMD_AGE_INIT;
            state_next = S_AGE_RD;
          end
          default: begin
            state_next = S_FIN;
          end
        endcase
      end
      // id lookup, high table then low table
      S_FIND_RD: begin
        if (st.ptr_end) begin
          if (st.list_lo) begin
            cmd = tps_pkg::CMD_NOT_FOUND;
            state_next = S_FIN;
          end else begin
            cmd = tps_pkg::CMD_NEXT_LIST;
          end
        end else begin
          state_next = S_FIND_EX;
        end
      end
      S_FIND_EX: begin
        if (st.id_match) begin
          cmd = tps_pkg::CMD_LATCH;
          state_next = S_DIFF;
        end else begin
          cmd = tps_pkg::CMD_PTR_INC;
          state_next = S_FIND_RD;
        end
      end
      S_DIFF: begin
        cmd = tps_pkg::CMD_DIFF;
        state_next = S_APPLY;
      end
      S_APPLY: begin
        cmd = tps_pkg::CMD_APPLY;
        state_next = S_FIN;
      end
      // compaction and due marking, high table then low table
      S_SCAN_RD: begin
        if (st.ptr_end) begin
          cmd = tps_pkg::CMD_SCAN_END;
          if (st.list_lo) begin
            state_next = S_FIN;
          end
        end else begin
          state_next = S_SCAN_EX;
        end
      end
      S_SCAN_EX: begin
        cmd = tps_pkg::CMD_SCAN_STEP;
        state_next = S_SCAN_RD;
      end
      // backward cursor walk for dispatch
      S_WALK_RD: begin
        if (st.walk_end) begin
          cmd = tps_pkg::CMD_WALK_END;
          state_next = S_WALK_NEXT;
        end else begin
          state_next = S_WALK_EX;
        end
      end
      S_WALK_EX: begin
        if (st.runnable) begin
          cmd = tps_pkg::CMD_WALK_HIT;
          state_next = S_FIN;
        end else begin
          cmd = tps_pkg::CMD_WALK_STEP;
          state_next = S_WALK_RD;
        end
      end
      S_WALK_NEXT: begin
        case (phase)
          PH_HI_FIRST: begin
            cmd = tps_pkg::CMD_WALK_LO;
            phase_next = PH_LO;
            state_next = S_WALK_RD;
          end
          PH_LO: begin
            if (st.age_ge) begin
              cmd = tps_pkg::CMD_WALK_HI;
              phase_next = PH_HI_LAST;
              state_next = S_WALK_RD;
            end else begin
              cmd = tps_pkg::CMD_NOT_DUE;
              state_next = S_FIN;
            end
          end
          default: begin
            cmd = tps_pkg::CMD_NOT_DUE;
            state_next = S_FIN;
          end
        endcase
      end
      // search for pending low work on budget expiry
      S_AGE_RD: begin
        if (st.ptr_end) begin
          state_next = S_FIN;
        end else begin
          state_next = S_AGE_EX;
        end
      end
      S_AGE_EX: begin
        if (st.runnable) begin
          cmd = tps_pkg::CMD_AGE_INC;
          state_next = S_FIN;
        end else begin
          cmd = tps_pkg::CMD_PTR_INC;
          state_next = S_AGE_RD;
        end
      end
      S_FIN: begin
        if (!st.out_busy) begin
          cmd = tps_pkg::CMD_OUT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= PH_HI_FIRST;
    end else begin
      state <= state_next;
      phase <= phase_next;
    end
  end

  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    cmd == tps_pkg::CMD_LOAD |-> in_valid && in_ready)
    else $error("beat loaded outside idle");
  a_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd == tps_pkg::CMD_OUT |-> !st.out_busy)
    else $error("result overwritten while pending");
  a_hit_runnable: assert property (@(posedge clk) disable iff (rst)
    cmd == tps_pkg::CMD_WALK_HIT |-> $past(state == S_WALK_RD))
    else $error("dispatch hit without a table read");

endmodule

// ===== rtl/two_priority_periodic_task_scheduler.sv =====
`timescale 1ns / 1ps
// an id lookup searches up to 2*TASKS_PER_LIST slots, high table first; a scan visits every slot
// of both tables; dispatch walks slots backward from each table's cursor; budget expiry searches
// the low table only; each slot visit costs one registered memory read
// one action in flight; the next beat is taken once the result sits in the output register
// rst (synchronous) empties both tables, clears cursors, ids and age, starvation limit to 5
module two_priority_periodic_task_scheduler #(
  parameter int TASKS_PER_LIST = 16,
  parameter int ID_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  tps_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output tps_pkg::out_beat_t out_data,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_wdata
);

  tps_pkg::cmd_t       cmd;
  tps_pkg::dp_status_t st;

  tps_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  tps_datapath #(
    .TASKS_PER_LIST (TASKS_PER_LIST),
    .ID_BITS        (ID_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .st        (st),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== dv/two_priority_periodic_task_scheduler_tb.sv =====
`timescale 1ns / 1ps
module two_priority_periodic_task_scheduler_tb;

  localparam int TASKS = 16;
  localparam int CYCLE_LIMIT = 2000000;

  // behavioral copy of the scheduler state and result queue
  class sched_scoreboard;
    logic [15:0] ids [2][TASKS];
    logic [31:0] ivals [2][TASKS];
    logic [31:0] dlines [2][TASKS];
    logic [15:0] reps [2][TASKS];
    logic [15:0] runs [2][TASKS];
    logic cancel_f [2][TASKS];
    logic due_f [2][TASKS];
    int count [2];
    int cursor [2];
    logic [15:0] last_id;
    logic [7:0] age;
    logic [7:0] starve_lim;
    tps_pkg::out_beat_t pending_results[$];
    int errors;

    function void clear();
      count = '{0, 0};
      cursor = '{0, 0};
      last_id = '0;
      age = '0;
      starve_lim = tps_pkg::STARVE_RESET;
      pending_results.delete();
      errors = 0;
    endfunction

    // lookup: high table first, first match wins
    function bit lookup(logic [15:0] id, output int l, output int p);
      for (int t = 0; t < 2; t++)
        for (int i = 0; i < count[t]; i++)
          if (ids[t][i] == id) begin
            l = t;
            p = i;
            return 1;
          end
      return 0;
    endfunction

    function logic [31:0] sat_sum(logic [31:0] a, logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function int back_one(int c, int n);
      return (c == 0 || c >= n) ? n - 1 : c - 1;
    endfunction

    // drop finished or cancelled tasks, keep cursor on the same task, or on the one before it if dropped
    function void squeeze(int l);
      int outp, newc;
      bit gone;
      outp = 0;
      newc = cursor[l];
      for (int i = 0; i < count[l]; i++) begin
        gone = (reps[l][i] != 0 && runs[l][i] == reps[l][i]) || cancel_f[l][i];
        if (gone) begin
          if (i == cursor[l]) newc = outp - 1;
        end else begin
          ids[l][outp] = ids[l][i];
          ivals[l][outp] = ivals[l][i];
          dlines[l][outp] = dlines[l][i];
          reps[l][outp] = reps[l][i];
          runs[l][outp] = runs[l][i];
          cancel_f[l][outp] = cancel_f[l][i];
          due_f[l][outp] = due_f[l][i];
          if (i == cursor[l]) newc = outp;
          outp++;
        end
      end
      count[l] = outp;
      if (outp == 0) newc = 0;
      else if (newc < 0 || newc >= outp) newc = outp - 1;
      cursor[l] = newc;
    endfunction

    function void arm_due(int l, logic [31:0] now);
      for (int i = 0; i < count[l]; i++)
        if (now > dlines[l][i]) begin
          due_f[l][i] = (dlines[l][i] != 0);
          dlines[l][i] = sat_sum(now, ivals[l][i]);
        end
    endfunction

    function bit walk(int l, output logic [15:0] id);
      int n, c;
      n = count[l];
      c = cursor[l];
      if (n == 0) return 0;
      if (c >= n) c = n - 1;
      for (int k = 0; k < n; k++) begin
        if (due_f[l][c] && !cancel_f[l][c]) begin
          cursor[l] = c;
          id = ids[l][c];
          return 1;
        end
        c = back_one(c, n);
      end
      cursor[l] = c;
      return 0;
    endfunction

    // note an accepted input beat and queue its expected result
    function void note_input(tps_pkg::in_beat_t b);
      tps_pkg::out_beat_t r;
      int l, p, h;
      logic [15:0] id;
      logic [31:0] d;
      r = '0;
      case (b.action)
        tps_pkg::ACT_ADD: begin
          h = b.high_priority ? 0 : 1;
          if (count[h] >= TASKS) r.status = tps_pkg::ST_FULL;
          else begin
            last_id = last_id + 16'd1;
            if (last_id == 0) last_id = 16'd1;
            p = count[h];
            ids[h][p] = last_id;
            ivals[h][p] = b.period_ms;
            dlines[h][p] = b.start_now ? b.now_ms : 32'd0;
            reps[h][p] = b.repetitions;
            runs[h][p] = '0;
            cancel_f[h][p] = 1'b0;
            due_f[h][p] = 1'b0;
            count[h]++;
            cursor[h]++;
            if (cursor[h] >= count[h]) cursor[h] = count[h] - 1;
            r.result_id = last_id;
          end
        end
        tps_pkg::ACT_CANCEL:
          if (lookup(b.task_id, l, p)) cancel_f[l][p] = 1'b1;
          else r.status = tps_pkg::ST_NOT_FOUND;
        tps_pkg::ACT_SET_IVAL:
          if (!lookup(b.task_id, l, p)) r.status = tps_pkg::ST_NOT_FOUND;
          else begin
            if (dlines[l][p] != 0) begin
              if (b.period_ms > ivals[l][p])
                dlines[l][p] = sat_sum(dlines[l][p], b.period_ms - ivals[l][p]);
              else if (b.period_ms < ivals[l][p]) begin
                d = ivals[l][p] - b.period_ms;
                dlines[l][p] = (dlines[l][p] > d) ? dlines[l][p] - d : 32'd1;
              end
            end
            ivals[l][p] = b.period_ms;
          end
        tps_pkg::ACT_SET_REPS:
          if (lookup(b.task_id, l, p)) reps[l][p] = b.repetitions;
          else r.status = tps_pkg::ST_NOT_FOUND;
        tps_pkg::ACT_QUERY: r.completed = !lookup(b.task_id, l, p);
        tps_pkg::ACT_SCAN: begin
          squeeze(0);
          squeeze(1);
          arm_due(1, b.now_ms);
          arm_due(0, b.now_ms);
        end
        tps_pkg::ACT_DISPATCH: begin
          if (age < starve_lim && walk(0, id)) begin
            r.result_id = id;
            r.result_high = 1'b1;
          end else if (walk(1, id)) begin
            r.result_id = id;
            age = '0;
          end else if (age >= starve_lim && walk(0, id)) begin
            r.result_id = id;
            r.result_high = 1'b1;
          end else r.status = tps_pkg::ST_NOT_DUE;
        end
        tps_pkg::ACT_BUDGET:
          for (int i = 0; i < count[1]; i++)
            if (due_f[1][i] && !cancel_f[1][i]) begin
              if (age < 8'd255) age++;
              break;
            end
        tps_pkg::ACT_TASK_DONE:
          if (!lookup(b.task_id, l, p)) r.status = tps_pkg::ST_NOT_FOUND;
          else begin
            if (!b.keep_going) begin
              due_f[l][p] = 1'b0;
              if (runs[l][p] != 16'hFFFF) runs[l][p]++;
            end
            if (p == cursor[l] && (!due_f[l][p] || cancel_f[l][p]))
              cursor[l] = back_one(cursor[l], count[l]);
          end
        default: ;
      endcase
      pending_results.push_back(r);
    endfunction

    function void check_result(tps_pkg::out_beat_t got);
      tps_pkg::out_beat_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result exp none got %p", $time, got);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      if (got.status !== want.status) begin
        $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
        errors++;
      end
      if (got.result_id !== want.result_id) begin
        $display("%0t: result_id exp %0d got %0d", $time, want.result_id, got.result_id);
        errors++;
      end
      if (got.result_high !== want.result_high) begin
        $display("%0t: result_high exp %0b got %0b", $time, want.result_high,
                 got.result_high);
        errors++;
      end
      if (got.completed !== want.completed) begin
        $display("%0t: completed exp %0b got %0b", $time, want.completed, got.completed);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  tps_pkg::in_beat_t in_data = '0;
  logic out_valid;
  logic out_ready = 0;
  tps_pkg::out_beat_t out_data;
  logic cfg_we = 0;
  logic [7:0] cfg_wdata = '0;

  sched_scoreboard sb;
  int cycles = 0;
  logic [31:0] clock_ms = 100;

  two_priority_periodic_task_scheduler #(.TASKS_PER_LIST(TASKS), .ID_BITS(16)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // timeout watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // result side: random stalls in stall mode, check every accepted beat
  bit stall_mode = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) sb.check_result(out_data);
      out_ready <= stall_mode ? ($urandom_range(0, 3) != 0) : 1'b1;
    end
  end

  // valid is always dropped between beats, with a random extra gap in stall mode
  task automatic send_beat(tps_pkg::in_beat_t b);
    int g;
    g = stall_mode ? gap_len() : 0;
    repeat (g + 1) @(posedge clk);
    in_valid <= 1;
    in_data <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(b);
    in_valid <= 0;
  endtask

  task automatic drain();
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic write_limit(logic [7:0] v);
    drain();
    cfg_we <= 1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
    sb.starve_lim = v;
  endtask

  function automatic logic [15:0] pick_id();
    int r, l;
    r = $urandom_range(0, 9);
    if (r < 7 && (sb.count[0] + sb.count[1]) > 0) begin
      l = (sb.count[0] == 0) ? 1 : (sb.count[1] == 0) ? 0 : $urandom_range(0, 1);
      return sb.ids[l][$urandom_range(0, sb.count[l] - 1)];
    end
    if (r == 7) return 16'hFFFF;
    return 16'($urandom());
  endfunction

  function automatic tps_pkg::in_beat_t mk(tps_pkg::action_t a);
    tps_pkg::in_beat_t b;
    b = '0;
    b.action = a;
    b.now_ms = clock_ms;
    b.task_id = pick_id();
    b.high_priority = 1'($urandom_range(0, 1));
    b.period_ms = ($urandom_range(0, 7) == 0) ? $urandom() : $urandom_range(0, 40);
    b.repetitions = ($urandom_range(0, 7) == 0) ? 16'($urandom()) :
                    16'($urandom_range(0, 4));
    b.start_now = 1'($urandom_range(0, 1));
    b.keep_going = ($urandom_range(0, 3) == 0);
    return b;
  endfunction

  // mostly well-formed traffic: scans advance time, dispatch then report completion
  task automatic random_phase(int n);
    tps_pkg::in_beat_t b;
    logic [15:0] run_id;
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 20) send_beat(mk(tps_pkg::ACT_ADD));
      else if (r < 32) begin
        clock_ms = clock_ms + $urandom_range(0, 30);
        send_beat(mk(tps_pkg::ACT_SCAN));
      end else if (r < 55) begin
        b = mk(tps_pkg::ACT_DISPATCH);
        send_beat(b);
        run_id = sb.pending_results[$].result_id;
        if (sb.pending_results[$].status == tps_pkg::ST_OK) begin
          if ($urandom_range(0, 2) == 0) send_beat(mk(tps_pkg::ACT_BUDGET));
          b = mk(tps_pkg::ACT_TASK_DONE);
          b.task_id = run_id;
          send_beat(b);
          i += 2;
        end
      end else if (r < 63) send_beat(mk(tps_pkg::ACT_BUDGET));
      else if (r < 70) send_beat(mk(tps_pkg::ACT_CANCEL));
      else if (r < 77) send_beat(mk(tps_pkg::ACT_SET_IVAL));
      else if (r < 83) send_beat(mk(tps_pkg::ACT_SET_REPS));
      else if (r < 89) send_beat(mk(tps_pkg::ACT_QUERY));
      else if (r < 95) send_beat(mk(tps_pkg::ACT_TASK_DONE));
      else begin
        b = mk(tps_pkg::ACT_ADD);
        b.action = tps_pkg::action_t'($urandom_range(0, 15));
        b.now_ms = clock_ms;
        send_beat(b);
      end
    end
  endtask

  initial begin
    tps_pkg::in_beat_t b;
    sb = new();
    sb.clear();
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: extremes, every action, special cases
    b = mk(tps_pkg::ACT_DISPATCH); send_beat(b);                 // nothing due
    b = mk(tps_pkg::ACT_CANCEL); b.task_id = 16'h0; send_beat(b); // not found
    b = mk(tps_pkg::ACT_ADD); b.high_priority = 1'b1; b.start_now = 1'b0;
    b.period_ms = 32'hFFFF_FFFF; b.repetitions = 16'hFFFF; send_beat(b);
    b = mk(tps_pkg::ACT_ADD); b.high_priority = 1'b0; b.start_now = 1'b1;
    b.period_ms = 32'd5; b.repetitions = 16'd1; send_beat(b);
    b = mk(tps_pkg::ACT_SCAN); b.now_ms = 32'hFFFF_FFFF; send_beat(b); // arm, saturate
    b = mk(tps_pkg::ACT_SET_IVAL); b.task_id = 16'd1; b.period_ms = 32'd0; send_beat(b);
    b = mk(tps_pkg::ACT_SET_IVAL); b.task_id = 16'd2; b.period_ms = 32'hFFFF_FFFF;
    send_beat(b);
    b = mk(tps_pkg::ACT_SET_REPS); b.task_id = 16'd1; b.repetitions = 16'd0; send_beat(b);
    b = mk(tps_pkg::ACT_QUERY); b.task_id = 16'd2; send_beat(b);
    b = mk(tps_pkg::ACT_QUERY); b.task_id = 16'hFFFF; send_beat(b);
    b = mk(tps_pkg::ACT_DISPATCH); send_beat(b);
    b = mk(tps_pkg::ACT_BUDGET); send_beat(b);
    b = mk(tps_pkg::ACT_TASK_DONE); b.task_id = 16'd2; b.keep_going = 1'b1; send_beat(b);
    b = mk(tps_pkg::ACT_TASK_DONE); b.task_id = 16'd2; b.keep_going = 1'b0; send_beat(b);
    b = mk(tps_pkg::ACT_CANCEL); b.task_id = 16'd1; send_beat(b);
    b = mk(tps_pkg::ACT_DISPATCH); send_beat(b);                 // cancelled not run
    b = mk(tps_pkg::ACT_SCAN); b.now_ms = 32'hFFFF_FFFF; send_beat(b); // remove finished
    b = mk(tps_pkg::ACT_ADD); b.action = tps_pkg::action_t'(4'hF); send_beat(b); // unknown
    for (int i = 0; i < TASKS + 1; i++) begin                    // fill high table
      b = mk(tps_pkg::ACT_ADD); b.high_priority = 1'b1; b.start_now = 1'b1;
      b.now_ms = 32'd0;
      send_beat(b);
    end

    // random phases across starvation settings
    write_limit(8'd1);
    stall_mode = 1;
    clock_ms = 200;
    b = mk(tps_pkg::ACT_SCAN); b.now_ms = 32'hFFFF_FFFF; send_beat(b);
    random_phase(300);
    write_limit(8'd255);
    stall_mode = 0;
    random_phase(200);
    write_limit(8'hAA);
    stall_mode = 1;
    random_phase(200);
    write_limit(8'h55);
    random_phase(200);
    write_limit(8'd2);
    random_phase(300);

    drain();
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
